>>> rtl/stcp_pkg.sv
package stcp_pkg;

  // Result kinds
  localparam logic [2:0] KIND_STATUS   = 3'd0;
  localparam logic [2:0] KIND_SAVE     = 3'd1;
  localparam logic [2:0] KIND_DEFAULT  = 3'd2;
  localparam logic [2:0] KIND_LOAD     = 3'd3;
  localparam logic [2:0] KIND_SET      = 3'd4;
  localparam logic [2:0] KIND_BADVAL   = 3'd5;
  localparam logic [2:0] KIND_BADCMD   = 3'd6;
  localparam logic [2:0] KIND_OVERFLOW = 3'd7;

  // Which scan the datapath runs over the stored line
  typedef enum logic [1:0] {
    PH_NONE,
    PH_SKIP,
    PH_WIN,
    PH_VAL
  } phase_t;

  // Controller to datapath
  typedef struct packed {
    logic       store;
    logic       clr_count;
    logic       start_scan;
    logic       start_val;
    logic       load_out;
    phase_t     phase;
    logic [2:0] out_kind;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       is_eol;
    logic       count_zero;
    logic       count_full;
    logic       blank;
    logic       found;
    logic       win_full;
    logic       dec_gain;
    logic [2:0] dec_kind;
    logic       val_end;
    logic       val_ok;
    logic       out_busy;
  } sts_t;

endpackage

>>> rtl/stcp_ram.sv
module stcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/stcp_dp.sv
module stcp_dp #(
  parameter int LINE_BYTES = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     rx_byte,
  input  stcp_pkg::cmd_t cmd,
  output stcp_pkg::sts_t sts,
  input  logic           out_tready,
  output logic           out_valid,
  output logic [2:0]     out_kind,
  output logic [1:0]     out_term,
  output logic           out_k,
  output logic [31:0]    out_value
);

  localparam int AW = $clog2(LINE_BYTES);
  localparam int IW = AW + 1;
  localparam logic [AW-1:0] LAST = AW'(LINE_BYTES - 1);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_D     = 8'h44;

  // Value scan substates
  localparam logic [1:0] VS_LEAD  = 2'd0;
  localparam logic [1:0] VS_SIGN  = 2'd1;
  localparam logic [1:0] VS_DIGIT = 2'd2;
  localparam logic [1:0] VS_TRAIL = 2'd3;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_skip(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_EQ);
  endfunction

  function automatic logic is_end(input logic [7:0] c);
    return (c == 8'd0) || is_skip(c);
  endfunction

  function automatic logic [2:0] term_of(input logic [7:0] c);
    logic [2:0] r;
    r = 3'b000;
    case (upcase(c))
      CH_P:    r = 3'b100;
      CH_I:    r = 3'b101;
      CH_D:    r = 3'b110;
      default: r = 3'b000;
    endcase
    return r;
  endfunction

  logic [AW-1:0] count_r;
  logic [IW-1:0] idx_r, idx_d_r, p_r;
  logic          rd_vld_r, zero_r;
  logic [7:0]    win_r [8];
  logic [2:0]    win_n_r;
  logic [31:0]   acc_r;
  logic          neg_r;
  logic [1:0]    vs_r;
  logic [1:0]    term_r;
  logic          k_r;
  logic          out_valid_r;
  logic [2:0]    out_kind_r;
  logic [1:0]    out_term_r;
  logic          out_k_r;
  logic [31:0]   out_value_r;

  logic [7:0]    rdata, ch;
  logic          ch_vld, scanning, is_digit;
  logic [3:0]    digit;
  logic [31:0]   acc_nxt;
  logic [7:0]    u [8];
  logic [2:0]    t0, t1;
  logic          dec_k;
  logic [1:0]    dec_term;
  logic          dec_gain;
  logic [2:0]    dec_kind;

  stcp_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_line (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (count_r),
    .wdata (rx_byte),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  // Effective character: zero past the stored count or after a zero byte
  assign scanning = (cmd.phase != stcp_pkg::PH_NONE);
  assign ch_vld   = rd_vld_r && scanning;
  assign ch       = (idx_d_r < IW'(count_r) && !zero_r) ? rdata : 8'd0;
  assign is_digit = (ch >= CH_0) && (ch <= CH_9);
  assign digit    = 4'(ch - CH_0);
  assign acc_nxt  = (acc_r << 3) + (acc_r << 1) + 32'(digit);

  // Command decision over the first eight characters
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      u[k] = upcase(win_r[k]);
    end
    t0 = term_of(win_r[0]);
    t1 = term_of(win_r[1]);
    dec_gain = 1'b0;
    dec_kind = stcp_pkg::KIND_BADCMD;
    dec_k = 1'b0;
    dec_term = 2'd0;
    if (win_r[0] == CH_QM && win_r[1] == 8'd0) begin
      dec_kind = stcp_pkg::KIND_STATUS;
    end else if ({u[0], u[1], u[2], u[3]} == 32'h53544154 && is_end(win_r[4])) begin
      dec_kind = stcp_pkg::KIND_STATUS;
    end else if ({u[0], u[1], u[2], u[3]} == 32'h53415645 && is_end(win_r[4])) begin
      dec_kind = stcp_pkg::KIND_SAVE;
    end else if ({u[0], u[1], u[2], u[3], u[4], u[5], u[6]} == 56'h44454641554C54
                 && is_end(win_r[7])) begin
      dec_kind = stcp_pkg::KIND_DEFAULT;
    end else if ({u[0], u[1], u[2], u[3]} == 32'h4C4F4144 && is_end(win_r[4])) begin
      dec_kind = stcp_pkg::KIND_LOAD;
    end else if (u[0] == CH_K && t1[2] && is_end(win_r[2])) begin
      dec_gain = 1'b1;
      dec_k = 1'b1;
      dec_term = t1[1:0];
    end else if (t0[2] && is_end(win_r[1])) begin
      dec_gain = 1'b1;
      dec_term = t0[1:0];
    end
  end

  // Status toward the controller
  always_comb begin
    sts.is_eol     = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    sts.count_zero = (count_r == '0);
    sts.count_full = (count_r == LAST);
    sts.blank      = ch_vld && (cmd.phase == stcp_pkg::PH_SKIP) && (ch == 8'd0);
    sts.found      = ch_vld && (cmd.phase == stcp_pkg::PH_SKIP) && !is_end(ch);
    sts.win_full   = ch_vld && (cmd.phase == stcp_pkg::PH_WIN) && (win_n_r == 3'd7);
    sts.dec_gain   = dec_gain;
    sts.dec_kind   = dec_kind;
    sts.val_end    = 1'b0;
    sts.val_ok     = 1'b0;
    if (ch_vld && cmd.phase == stcp_pkg::PH_VAL) begin
      case (vs_r)
        VS_LEAD: begin
          sts.val_end = !is_skip(ch) && ch != CH_MINUS && ch != CH_PLUS && !is_digit;
        end
        VS_SIGN: begin
          sts.val_end = !is_digit;
        end
        VS_DIGIT: begin
          sts.val_end = !is_digit && !is_skip(ch);
          sts.val_ok  = (ch == 8'd0);
        end
        default: begin
          sts.val_end = !is_skip(ch);
          sts.val_ok  = (ch == 8'd0);
        end
      endcase
    end
    sts.out_busy = out_valid_r && !out_tready;
  end

  // Line count and read pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_vld_r <= 1'b0;
      zero_r   <= 1'b0;
    end else begin
      if (cmd.clr_count) begin
        count_r <= '0;
      end else if (cmd.store) begin
        count_r <= count_r + 1'b1;
      end
      // scan starts are issued with no phase active, so this drops low there
      rd_vld_r <= scanning;
      if (cmd.start_scan || cmd.start_val) begin
        zero_r <= 1'b0;
      end else if (ch_vld && cmd.phase == stcp_pkg::PH_WIN && ch == 8'd0) begin
        zero_r <= 1'b1;
      end
    end
  end

  // Scan datapath: index, window and value accumulator
  always_ff @(posedge clk) begin
    idx_d_r <= idx_r;
    if (cmd.start_scan) begin
      idx_r <= '0;
    end else if (cmd.start_val) begin
      idx_r  <= p_r + (dec_k ? IW'(2) : IW'(1));
      term_r <= dec_term;
      k_r    <= dec_k;
      acc_r  <= '0;
      neg_r  <= 1'b0;
      vs_r   <= VS_LEAD;
    end else if (scanning) begin
      idx_r <= idx_r + 1'b1;
    end
    if (sts.found) begin
      p_r      <= idx_d_r;
      win_r[0] <= ch;
      win_n_r  <= 3'd1;
    end else if (ch_vld && cmd.phase == stcp_pkg::PH_WIN) begin
      win_r[win_n_r] <= ch;
      win_n_r        <= win_n_r + 1'b1;
    end
    if (ch_vld && cmd.phase == stcp_pkg::PH_VAL) begin
      case (vs_r)
        VS_LEAD: begin
          if (ch == CH_MINUS) begin
            neg_r <= 1'b1;
            vs_r  <= VS_SIGN;
          end else if (ch == CH_PLUS) begin
            vs_r <= VS_SIGN;
          end else if (is_digit) begin
            acc_r <= 32'(digit);
            vs_r  <= VS_DIGIT;
          end
        end
        VS_SIGN: begin
          acc_r <= 32'(digit);
          vs_r  <= VS_DIGIT;
        end
        VS_DIGIT: begin
          if (is_digit) begin
            acc_r <= acc_nxt;
          end else begin
            vs_r <= VS_TRAIL;
          end
        end
        default: begin
          vs_r <= VS_TRAIL;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load_out) begin
      out_kind_r <= cmd.out_kind;
      if (cmd.out_kind == stcp_pkg::KIND_SET) begin
        out_term_r  <= term_r;
        out_k_r     <= k_r;
        out_value_r <= neg_r ? (32'd0 - acc_r) : acc_r;
      end else begin
        out_term_r  <= '0;
        out_k_r     <= 1'b0;
        out_value_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_term  = out_term_r;
  assign out_k     = out_k_r;
  assign out_value = out_value_r;

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result overwritten before taken");

  // The line store never writes past its last usable entry
  a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> (count_r != LAST))
    else $error("store into a full line");

  // A new result appears only after a load command
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.load_out))
    else $error("result valid without load");

endmodule

>>> rtl/stcp_ctrl.sv
module stcp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  stcp_pkg::sts_t sts,
  output stcp_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SKIP,
    S_WIN,
    S_DEC,
    S_VAL,
    S_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] kind_r, kind_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    cmd           = '0;
    cmd.phase     = stcp_pkg::PH_NONE;
    cmd.out_kind  = kind_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (sts.is_eol) begin
            // count is kept through the parse to bound the scans
            if (!sts.count_zero) begin
              cmd.start_scan = 1'b1;
              state_nxt      = S_SKIP;
            end
          end else if (!sts.count_full) begin
            cmd.store = 1'b1;
          end else begin
            cmd.clr_count = 1'b1;
            kind_nxt      = stcp_pkg::KIND_OVERFLOW;
            state_nxt     = S_EMIT;
          end
        end
      end
      S_SKIP: begin
        cmd.phase = stcp_pkg::PH_SKIP;
        if (sts.blank) begin
          cmd.clr_count = 1'b1;
          state_nxt     = S_IDLE;
        end else if (sts.found) begin
          state_nxt = S_WIN;
        end
      end
      S_WIN: begin
        cmd.phase = stcp_pkg::PH_WIN;
        if (sts.win_full) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.dec_gain) begin
          cmd.start_val = 1'b1;
          state_nxt     = S_VAL;
        end else begin
          kind_nxt  = sts.dec_kind;
          state_nxt = S_EMIT;
        end
      end
      S_VAL: begin
        cmd.phase = stcp_pkg::PH_VAL;
        if (sts.val_end) begin
          kind_nxt  = sts.val_ok ? stcp_pkg::KIND_SET : stcp_pkg::KIND_BADVAL;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // parse is over: start the next line empty
        cmd.clr_count = 1'b1;
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= stcp_pkg::KIND_STATUS;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

>>> rtl/serial_text_command_parser_top.sv
// Serial text command parser.
// Input channel (in_*): one received character per transaction in in_tdata.
// Result channel (out_*): one command result per finished non-blank line;
// the kind is in out_tuser, the gain term, K flag and signed value in out_tdata.
// Ordinary characters are written into the line memory as they arrive;
// in_tready stays high for them, so they can follow back to back.
// CR or LF on a non-empty line starts a parse that walks the stored line:
// leading blanks are scanned, the next eight characters are collected to
// pick the command, and for a gain set the value is scanned again from just
// after the gain name. The parse reads the line through the single registered
// read port of the line memory (one character per cycle), and the result is
// loaded when the parse ends. A line that grows too long gives an overflow
// result and restarts. in_tready stays low during the parse.
// When the receiver stalls, one result waits in the output register; the
// parse of the next line may finish and then holds until that result is
// taken. Reset empties the line and drops any pending result.
module serial_text_command_parser_top #(
  parameter int LINE_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [1:0] gain_term, [2] k_prefixed, [34:3] gain_value
  output logic [2:0]  out_tuser   // [2:0] command_kind
);

  stcp_pkg::cmd_t cmd;
  stcp_pkg::sts_t sts;
  logic [1:0]     term;
  logic           k;
  logic [31:0]    value;

  stcp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  stcp_dp #(.LINE_BYTES(LINE_BYTES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_byte    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_kind   (out_tuser),
    .out_term   (term),
    .out_k      (k),
    .out_value  (value)
  );

  assign out_tdata = {5'd0, value, k, term};

endmodule
